/* hdl/lplfi_pkg.sv */
package lplfi_pkg;

  // Frame geometry
  localparam int CHECK_WORDS = 32;
  localparam int FADE_FRAMES = 960;

  // Field widths
  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 16;
  localparam int COUNT_W  = 8;
  localparam int OUT_W    = 32;
  localparam int FI_W     = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Derived widths
  localparam int WP_W   = $clog2(CHECK_WORDS + 1);
  localparam int MAG_W  = SAMPLE_W + GAIN_W;
  localparam int PROD_W = MAG_W + FI_W;
  localparam int RQ_W   = $clog2(FADE_FRAMES + 1);
  localparam int CNT_W  = $clog2(PROD_W);

  localparam logic [FI_W-1:0]   FADE_LIMIT = FI_W'(FADE_FRAMES);
  localparam logic [RQ_W:0]     DIVISOR    = (RQ_W + 1)'(FADE_FRAMES);
  localparam logic [WP_W:0]     WP_LIMIT   = (WP_W + 1)'(CHECK_WORDS);
  localparam logic [PROD_W-1:0] POS_LIM    =
    {{(PROD_W - OUT_W + 1){1'b0}}, {(OUT_W - 1){1'b1}}};
  localparam logic [PROD_W-1:0] NEG_LIM    =
    {{(PROD_W - OUT_W){1'b0}}, 1'b1, {(OUT_W - 1){1'b0}}};

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_PATTERN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_NEEDED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LINK_GAIN     = 2'd2;

  // Reset values
  localparam logic [SAMPLE_W-1:0] IDLE_PATTERN_RST  = 16'h96A5;
  localparam logic [COUNT_W-1:0]  BLOCKS_NEEDED_RST = 8'd8;
  localparam logic [GAIN_W-1:0]   LINK_GAIN_RST     = 16'd16384;

  typedef enum logic [1:0] {
    MODE_ZERO,
    MODE_FULL,
    MODE_FADE
  } lplfi_mode_t;

  typedef struct packed {
    lplfi_mode_t     mode;
    logic [FI_W-1:0] idx;
  } lplfi_audio_ctl_t;

  // Saturate a magnitude with sign to signed OUT_W bits.
  function automatic logic [OUT_W-1:0] sat_mag(input logic [PROD_W-1:0] mag,
                                               input logic neg);
    logic [OUT_W-1:0] r;
    if (neg) begin
      if (mag > NEG_LIM) r = {1'b1, {(OUT_W - 1){1'b0}}};
      else               r = ~mag[OUT_W-1:0] + OUT_W'(1);
    end else begin
      if (mag > POS_LIM) r = {1'b0, {(OUT_W - 1){1'b1}}};
      else               r = mag[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

/* hdl/lplfi_in_if.sv */
interface lplfi_in_if;
  import lplfi_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_sample;
  logic signed [SAMPLE_W-1:0] right_sample;
  logic                       partner_ready;
  logic                       block_last;

  modport source (output valid, left_sample, right_sample, partner_ready, block_last,
                  input ready);
  modport sink (input valid, left_sample, right_sample, partner_ready, block_last,
                output ready);
endinterface

/* hdl/lplfi_out_if.sv */
interface lplfi_out_if;
  import lplfi_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] left_out;
  logic signed [OUT_W-1:0] right_out;
  logic                    locked;
  logic                    ready_out;

  modport source (output valid, left_out, right_out, locked, ready_out, input ready);
  modport sink (input valid, left_out, right_out, locked, ready_out, output ready);
endinterface

/* hdl/lplfi_cfg_if.sv */
interface lplfi_cfg_if;
  import lplfi_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hdl/lplfi_lock.sv */
module lplfi_lock (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           accept,
  input  logic [lplfi_pkg::SAMPLE_W-1:0] left_word,
  input  logic [lplfi_pkg::SAMPLE_W-1:0] right_word,
  input  logic                           partner_ready,
  input  logic                           block_last,
  input  logic [lplfi_pkg::SAMPLE_W-1:0] idle_pattern,
  input  logic [lplfi_pkg::COUNT_W-1:0]  blocks_needed,
  output lplfi_pkg::lplfi_audio_ctl_t    audio_ctl,
  output logic                           locked_nxt
);
  import lplfi_pkg::*;

  logic [COUNT_W-1:0] sc_r, sc_nxt;
  logic               lock_r, lock_nxt;
  logic               fr_r, fr_nxt;
  logic [FI_W-1:0]    fi_r, fi_nxt;
  logic               mm_r, mm_nxt;
  logic [WP_W-1:0]    wp_r, wp_nxt;
  logic               mm;
  logic [WP_W:0]      wp_sum;

  always_comb begin
    sc_nxt    = sc_r;
    lock_nxt  = lock_r;
    fr_nxt    = fr_r;
    fi_nxt    = fi_r;
    mm_nxt    = mm_r;
    wp_nxt    = wp_r;
    mm        = mm_r;
    wp_sum    = {1'b0, wp_r} + (WP_W + 1)'(2);
    audio_ctl = '{mode: MODE_ZERO, idx: '0};
    if (!partner_ready) begin
      sc_nxt   = '0;
      lock_nxt = 1'b0;
      fr_nxt   = 1'b0;
      fi_nxt   = '0;
      mm_nxt   = 1'b0;
      wp_nxt   = '0;
    end else begin
      // audio uses the lock state from before this frame's block end
      if (lock_r) begin
        audio_ctl.mode = MODE_FULL;
        if (fr_r) begin
          if (fi_r < FADE_LIMIT) begin
            audio_ctl.mode = MODE_FADE;
            audio_ctl.idx  = fi_r;
            fi_nxt         = fi_r + FI_W'(1);
          end else begin
            fr_nxt = 1'b0;
          end
        end
      end
      if ({1'b0, wp_r} < WP_LIMIT && left_word != idle_pattern) mm = 1'b1;
      if ({1'b0, wp_r} + (WP_W + 1)'(1) < WP_LIMIT && right_word != idle_pattern) mm = 1'b1;
      mm_nxt = mm;
      wp_nxt = (wp_sum > WP_LIMIT) ? WP_LIMIT[WP_W-1:0] : wp_sum[WP_W-1:0];
      if (block_last) begin
        if (mm)                         sc_nxt = '0;
        else if (sc_r < blocks_needed)  sc_nxt = sc_r + COUNT_W'(1);
        if (sc_nxt >= blocks_needed && !lock_r) begin
          fi_nxt   = '0;
          fr_nxt   = 1'b1;
          lock_nxt = 1'b1;
        end
        mm_nxt = 1'b0;
        wp_nxt = '0;
      end
    end
    locked_nxt = lock_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_r   <= '0;
      lock_r <= 1'b0;
      fr_r   <= 1'b0;
      fi_r   <= '0;
      mm_r   <= 1'b0;
      wp_r   <= '0;
    end else if (accept) begin
      sc_r   <= sc_nxt;
      lock_r <= lock_nxt;
      fr_r   <= fr_nxt;
      fi_r   <= fi_nxt;
      mm_r   <= mm_nxt;
      wp_r   <= wp_nxt;
    end
  end

endmodule

/* hdl/lplfi_scale.sv */
module lplfi_scale (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic signed [lplfi_pkg::SAMPLE_W-1:0] sample,
  input  logic [lplfi_pkg::GAIN_W-1:0]          gain,
  input  lplfi_pkg::lplfi_audio_ctl_t           audio_ctl,
  output logic                                  busy,
  output logic signed [lplfi_pkg::OUT_W-1:0]    result
);
  import lplfi_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_DIV
  } lane_state_t;

  lane_state_t          state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [SAMPLE_W-1:0]  mplier_r, mplier_nxt;
  logic [GAIN_W-1:0]    mcand_r, mcand_nxt;
  logic [PROD_W-1:0]    acc_r, acc_nxt;
  logic [MAG_W-1:0]     mag_r, mag_nxt;
  logic [FI_W-1:0]      idx_r, idx_nxt;
  logic                 neg_r, neg_nxt;
  lplfi_mode_t          mode_r, mode_nxt;
  logic [RQ_W-1:0]      rem_r, rem_nxt;
  logic [OUT_W-1:0]     res_r, res_nxt;
  logic [RQ_W:0]        trial;
  logic                 ge;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    mplier_nxt = mplier_r;
    mcand_nxt  = mcand_r;
    acc_nxt    = acc_r;
    mag_nxt    = mag_r;
    idx_nxt    = idx_r;
    neg_nxt    = neg_r;
    mode_nxt   = mode_r;
    rem_nxt    = rem_r;
    res_nxt    = res_r;
    trial      = {rem_r, acc_r[PROD_W-1]};
    ge         = trial >= DIVISOR;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          neg_nxt    = sample[SAMPLE_W-1];
          mplier_nxt = sample[SAMPLE_W-1] ? (~sample + SAMPLE_W'(1)) : sample;
          mcand_nxt  = gain;
          mode_nxt   = audio_ctl.mode;
          idx_nxt    = audio_ctl.idx;
          acc_nxt    = '0;
          cnt_nxt    = '0;
          state_nxt  = S_MUL1;
        end
      end
      S_MUL1: begin
        // |sample| * gain, one multiplier bit a cycle, MSB first
        acc_nxt    = {acc_r[PROD_W-2:0], 1'b0} +
                     (mplier_r[SAMPLE_W-1] ? PROD_W'(mcand_r) : '0);
        mplier_nxt = {mplier_r[SAMPLE_W-2:0], 1'b0};
        cnt_nxt    = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(SAMPLE_W - 1)) begin
          mag_nxt = {acc_nxt[MAG_W-2:0], 1'b0};
          cnt_nxt = '0;
          if (mode_r == MODE_FADE) begin
            acc_nxt   = '0;
            state_nxt = S_MUL2;
          end else begin
            res_nxt   = (mode_r == MODE_ZERO) ? '0 :
                        sat_mag(PROD_W'({acc_nxt[MAG_W-2:0], 1'b0}), neg_r);
            state_nxt = S_IDLE;
          end
        end
      end
      S_MUL2: begin
        acc_nxt = {acc_r[PROD_W-2:0], 1'b0} +
                  (idx_r[FI_W-1] ? PROD_W'(mag_r) : '0);
        idx_nxt = {idx_r[FI_W-2:0], 1'b0};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(FI_W - 1)) begin
          cnt_nxt   = '0;
          rem_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        // restoring division by the fade length, quotient shifts in at the bottom
        rem_nxt = ge ? RQ_W'(trial - DIVISOR) : trial[RQ_W-1:0];
        acc_nxt = {acc_r[PROD_W-2:0], ge};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(PROD_W - 1)) begin
          res_nxt   = sat_mag(acc_nxt, neg_r);
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    cnt_r    <= cnt_nxt;
    mplier_r <= mplier_nxt;
    mcand_r  <= mcand_nxt;
    acc_r    <= acc_nxt;
    mag_r    <= mag_nxt;
    idx_r    <= idx_nxt;
    neg_r    <= neg_nxt;
    mode_r   <= mode_nxt;
    rem_r    <= rem_nxt;
    res_r    <= res_nxt;
  end

  assign busy   = (state_r != S_IDLE);
  assign result = $signed(res_r);

endmodule

/* hdl/link_pattern_lock_fade_in_top.sv */
// Secondary audio link receiver: checks the first CHECK_WORDS sample words of each
// block against the idle pattern, declares lock after blocks_needed clean blocks
// in a row, then scales each stereo frame by link_gain with a linear fade-in over
// FADE_FRAMES frames, saturated to signed 32 bits. One frame is in work at a time;
// both channels run through a bit-serial multiply and, while the fade runs, a
// second multiply by the fade step and a restoring divide by FADE_FRAMES. A
// finished word waits in the output register while the next frame is accepted. A
// low partner_ready clears all lock state and yields zero audio. Registers are
// written through the configuration channel, which is always ready.
module link_pattern_lock_fade_in_top (
  input logic        clk,
  input logic        rst_n,
  lplfi_in_if.sink   in_ch,
  lplfi_out_if.source out_ch,
  lplfi_cfg_if.sink  cfg_ch
);
  import lplfi_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_BUSY
  } top_state_t;

  top_state_t               state_r;
  logic                     out_valid_r;
  logic signed [OUT_W-1:0]  left_r;
  logic signed [OUT_W-1:0]  right_r;
  logic                     locked_out_r;
  logic                     locked_pend_r;
  logic [SAMPLE_W-1:0]      idle_pattern_r;
  logic [COUNT_W-1:0]       blocks_needed_r;
  logic [GAIN_W-1:0]        link_gain_r;
  logic                     in_fire;
  logic                     lanes_busy;
  logic                     out_load;
  logic                     busy_l, busy_r;
  logic signed [OUT_W-1:0]  res_l, res_r;
  lplfi_audio_ctl_t         audio_ctl;
  logic                     locked_nxt;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign lanes_busy   = busy_l || busy_r;
  assign cfg_ch.ready = 1'b1;
  // hand the word over once both lanes finish and the output slot is free
  assign out_load     = (state_r == ST_BUSY) && !lanes_busy &&
                        (!out_valid_r || out_ch.ready);

  lplfi_lock u_lock (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_fire),
    .left_word    (in_ch.left_sample),
    .right_word   (in_ch.right_sample),
    .partner_ready(in_ch.partner_ready),
    .block_last   (in_ch.block_last),
    .idle_pattern (idle_pattern_r),
    .blocks_needed(blocks_needed_r),
    .audio_ctl    (audio_ctl),
    .locked_nxt   (locked_nxt)
  );

  lplfi_scale u_scale_l (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_fire),
    .sample   (in_ch.left_sample),
    .gain     (link_gain_r),
    .audio_ctl(audio_ctl),
    .busy     (busy_l),
    .result   (res_l)
  );

  lplfi_scale u_scale_r (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_fire),
    .sample   (in_ch.right_sample),
    .gain     (link_gain_r),
    .audio_ctl(audio_ctl),
    .busy     (busy_r),
    .result   (res_r)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_pattern_r  <= IDLE_PATTERN_RST;
      blocks_needed_r <= BLOCKS_NEEDED_RST;
      link_gain_r     <= LINK_GAIN_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_IDLE_PATTERN:  idle_pattern_r  <= cfg_ch.data;
        REG_BLOCKS_NEEDED: blocks_needed_r <= cfg_ch.data[COUNT_W-1:0];
        REG_LINK_GAIN:     link_gain_r     <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            locked_pend_r <= locked_nxt;
            state_r       <= ST_BUSY;
          end
        end
        ST_BUSY: begin
          if (out_load) begin
            left_r       <= res_l;
            right_r      <= res_r;
            locked_out_r <= locked_pend_r;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.left_out  = left_r;
  assign out_ch.right_out = right_r;
  assign out_ch.locked    = locked_out_r;
  assign out_ch.ready_out = locked_out_r;

  a_lanes_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (busy_l && busy_r && state_r == ST_BUSY))
    else $error("lanes not started on accepted frame");

  a_lanes_together: assert property (@(posedge clk) disable iff (!rst_n)
    busy_l == busy_r)
    else $error("channel lanes out of step");

  a_unlocked_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !locked_out_r) |-> (left_r == '0 && right_r == '0))
    else $error("audio while unlocked");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    lanes_busy |-> !in_ch.ready)
    else $error("frame accepted while lanes busy");

endmodule
